@@ sv/tmcw_pkg.sv @@
package tmcw_pkg;

  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_ROWS_DEF    = 25;
  localparam int TAB_STOP           = 8;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LINE_FEED = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // APB register index (paddr[2])
  localparam logic [0:0] REG_COLOUR_ATTR = 1'b0;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_REPORT,
    ST_COPY,
    ST_ZERO
  } state_e;

  typedef struct packed {
    logic accept;
    logic home;
    logic put_exec;
    logic copy_init;
    logic copy_step;
    logic zero_init;
    logic zero_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scroll;
    logic copy_done;
    logic sweep_done;
  } ctrl_stat_t;

endpackage

@@ sv/tmcw_regs.sv @@
module tmcw_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  attr
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tmcw_pkg::ATTR_RESET;
    end else if (wr_en && (paddr[2:2] == tmcw_pkg::REG_COLOUR_ATTR)) begin
      attr <= pwdata[7:0];
    end
  end

  // low address bits select a byte lane and are ignored
  always_comb begin
    if (paddr[2:2] == tmcw_pkg::REG_COLOUR_ATTR) begin
      prdata = {24'd0, attr};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

@@ sv/tmcw_ctrl.sv @@
module tmcw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             operation,
  input  tmcw_pkg::ctrl_stat_t   stat,
  output tmcw_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);

  tmcw_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      tmcw_pkg::ST_INIT: begin
        cmd.zero_step = 1'b1;
        if (stat.sweep_done) begin
          state_next = tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (operation == tmcw_pkg::OP_PUT) begin
            state_next = tmcw_pkg::ST_PUT;
          end else if (operation == tmcw_pkg::OP_CLEAR) begin
            cmd.home      = 1'b1;
            cmd.zero_init = 1'b1;
            state_next    = tmcw_pkg::ST_ZERO;
          end else begin
            state_next = tmcw_pkg::ST_REPORT;
          end
        end
      end
      tmcw_pkg::ST_PUT: begin
        cmd.put_exec = 1'b1;
        if (stat.scroll) begin
          cmd.copy_init = 1'b1;
          state_next    = tmcw_pkg::ST_COPY;
        end else begin
          cmd.emit   = 1'b1;
          state_next = tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_REPORT: begin
        cmd.emit   = 1'b1;
        state_next = tmcw_pkg::ST_IDLE;
      end
      tmcw_pkg::ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) begin
          state_next = tmcw_pkg::ST_ZERO;
        end
      end
      tmcw_pkg::ST_ZERO: begin
        cmd.zero_step = 1'b1;
        if (stat.sweep_done) begin
          cmd.emit   = 1'b1;
          state_next = tmcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmcw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/tmcw_dp.sv @@
module tmcw_dp #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmcw_pkg::req_t       request,
  input  logic [7:0]           attr,
  input  tmcw_pkg::ctrl_cmd_t  cmd,
  output tmcw_pkg::ctrl_stat_t stat,
  output logic                 done,
  output tmcw_pkg::result_t    result
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_COUNT = SCREEN_COLUMNS * (SCREEN_ROWS - 2);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CNW        = $clog2(CELL_COUNT + 1);
  localparam int RW         = $clog2(SCREEN_ROWS);
  localparam int CW         = $clog2(SCREEN_COLUMNS + tmcw_pkg::TAB_STOP);

  logic [15:0]    mem [CELL_COUNT];
  logic [15:0]    rd_data;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [15:0]    wr_data;
  logic           wr_en;

  logic [RW-1:0]  row;
  logic [CW-1:0]  col;
  logic [7:0]     ch_q;
  logic           read_hit;
  logic [CNW-1:0] cnt;

  logic [31:0]    idx_ext;
  logic [CNW-1:0] cnt_m1;
  logic [CNW-1:0] copy_src;

  // put-character evaluation
  logic [CW-1:0]  col_a, col_w, store_col;
  logic [RW-1:0]  row_a, row_w, put_row;
  logic           put_we;
  logic           need_scroll;
  logic [7:0]     store_char;
  logic [AW-1:0]  store_addr;

  logic [RW-1:0]  row_n;
  logic [CW-1:0]  col_n;
  logic [AW-1:0]  off_n;
  logic [31:0]    row32, col32, off32;

  assign idx_ext  = 32'(request.cell_index);
  assign cnt_m1   = cnt - CNW'(1);
  assign copy_src = cnt + CNW'(SCREEN_COLUMNS);

  always_comb begin
    col_a      = col;
    row_a      = row;
    put_we     = 1'b0;
    store_col  = col;
    store_char = ch_q;
    unique case (ch_q)
      tmcw_pkg::CH_BACKSPACE: begin
        if (col != '0) begin
          col_a      = col - CW'(1);
          store_col  = col - CW'(1);
          store_char = tmcw_pkg::CH_SPACE;
          put_we     = 1'b1;
        end
      end
      tmcw_pkg::CH_TAB: begin
        col_a = (col + CW'(tmcw_pkg::TAB_STOP)) & ~CW'(tmcw_pkg::TAB_STOP - 1);
      end
      tmcw_pkg::CH_RETURN: begin
        col_a = '0;
      end
      tmcw_pkg::CH_LINE_FEED: begin
        col_a = '0;
        row_a = row + RW'(1);
      end
      default: begin
        put_we = 1'b1;
        col_a  = col + CW'(1);
      end
    endcase

    if (col_a >= CW'(SCREEN_COLUMNS)) begin
      col_w = '0;
      row_w = row_a + RW'(1);
    end else begin
      col_w = col_a;
      row_w = row_a;
    end

    need_scroll = (row_w >= RW'(SCREEN_ROWS - 1));
    put_row     = need_scroll ? row_w - RW'(1) : row_w;
  end

  assign store_addr = AW'(row) * AW'(SCREEN_COLUMNS) + AW'(store_col);

  assign stat.scroll     = need_scroll;
  assign stat.copy_done  = (cnt == CNW'(COPY_COUNT));
  assign stat.sweep_done = (cnt == CNW'(CELL_COUNT));

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_m1[AW-1:0];
    wr_data = 16'd0;
    if (cmd.put_exec && put_we) begin
      wr_en   = 1'b1;
      wr_addr = store_addr;
      wr_data = {attr, store_char};
    end else if (cmd.copy_step) begin
      wr_en   = (cnt != '0);
      wr_data = rd_data;
    end else if (cmd.zero_step) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = cmd.copy_step ? copy_src[AW-1:0] : idx_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_q     <= request.char_code;
      read_hit <= (request.operation == tmcw_pkg::OP_READ) && (idx_ext < 32'(CELL_COUNT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNW'(1);
    end else if (cmd.zero_init) begin
      cnt <= CNW'(1);
    end else if (cmd.copy_init) begin
      cnt <= '0;
    end else if (cmd.copy_step || cmd.zero_step) begin
      cnt <= cnt + CNW'(1);
    end
  end

  always_comb begin
    if (cmd.put_exec) begin
      row_n = put_row;
      col_n = col_w;
    end else if (cmd.home) begin
      row_n = '0;
      col_n = '0;
    end else begin
      row_n = row;
      col_n = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_n;
      col <= col_n;
    end
  end

  assign off_n = AW'(row_n) * AW'(SCREEN_COLUMNS) + AW'(col_n);
  assign row32 = 32'(row_n);
  assign col32 = 32'(col_n);
  assign off32 = 32'(off_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.cursor_row    <= row32[4:0];
      result.cursor_column <= col32[6:0];
      result.cursor_offset <= off32[10:0];
      result.cell_data     <= read_hit ? rd_data : 16'd0;
    end
  end

endmodule

@@ sv/text_mode_console_writer.sv @@
// Start accepted to done: put passes through ST_PUT, read and the unused code
// through ST_REPORT. A put that scrolls then copies COLUMNS*(ROWS-2) cells up a row
// and zeroes 2*COLUMNS cells (ST_COPY, ST_ZERO); a clear zeroes COLUMNS*ROWS cells.
// One transaction at a time, the next taken in the done cycle; scrolls and clears
// keep busy high through their screen memory sweeps.
// Synchronous reset homes the cursor, loads attribute 0x0F and then zeroes the
// screen, one cell a cycle with busy high; the receiver cannot stall.
module text_mode_console_writer #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tmcw_pkg::req_t    request,
  output logic              done,
  output tmcw_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]           attr;
  tmcw_pkg::ctrl_cmd_t  cmd;
  tmcw_pkg::ctrl_stat_t stat;

  tmcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  tmcw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .attr    (attr),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

@@ sv/tmcw_checker.sv @@
module tmcw_checker #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input tmcw_pkg::result_t result
);

  // an accepted transaction holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  // every result comes out of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result per transaction");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    done |-> ((32'(result.cursor_column) < SCREEN_COLUMNS) &&
              (32'(result.cursor_row) < SCREEN_ROWS - 1)))
    else $error("cursor reported off screen");

endmodule

bind text_mode_console_writer tmcw_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_tmcw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
